// ----- rtl/md5he_pkg.sv -----
// MD5 engine package: step, jump and phase codes, control word, microprogram and round tables.
package md5he_pkg;

   localparam int STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type S_IDLE  = 3'd0;
   localparam step_type S_PAD   = 3'd1;
   localparam step_type S_CLOAD = 3'd2;
   localparam step_type S_ROUND = 3'd3;
   localparam step_type S_CADD  = 3'd4;
   localparam step_type S_EMIT  = 3'd5;

   typedef logic [2:0] jmp_type;

   localparam jmp_type J_INPUT = 3'd0;
   localparam jmp_type J_WRAP  = 3'd1;
   localparam jmp_type J_NEXT  = 3'd2;
   localparam jmp_type J_LOOP  = 3'd3;
   localparam jmp_type J_RET   = 3'd4;
   localparam jmp_type J_EMIT  = 3'd5;
   localparam jmp_type J_HOME  = 3'd6;

   typedef logic [1:0] phase_type;

   localparam phase_type PH_NONE = 2'd0;
   localparam phase_type PH_MARK = 2'd1;
   localparam phase_type PH_ZERO = 2'd2;
   localparam phase_type PH_LEN  = 2'd3;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hEFCDAB89;
   localparam logic [31:0] INIT_C = 32'h98BADCFE;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [5:0]  LAST_ROUND = 6'd63;

   typedef struct packed {
      logic    in_ready;
      logic    pad_push;
      logic    work_load;
      logic    round_en;
      logic    chain_add;
      logic    emit;
      jmp_type jmp;
   } ctl_type;

   function automatic ctl_type ucode(step_type s);
      ctl_type c;
      c = '0;
      case (s)
         S_IDLE: begin
            c.in_ready = 1'b1;
            c.jmp      = J_INPUT;
         end
         S_PAD: begin
            c.pad_push = 1'b1;
            c.jmp      = J_WRAP;
         end
         S_CLOAD: begin
            c.work_load = 1'b1;
            c.jmp       = J_NEXT;
         end
         S_ROUND: begin
            c.round_en = 1'b1;
            c.jmp      = J_LOOP;
         end
         S_CADD: begin
            c.chain_add = 1'b1;
            c.jmp       = J_RET;
         end
         S_EMIT: begin
            c.emit = 1'b1;
            c.jmp  = J_EMIT;
         end
         default: begin
            c.jmp = J_HOME;
         end
      endcase
      return c;
   endfunction

   function automatic logic [31:0] sine_k(logic [5:0] j);
      logic [31:0] k;
      case (j)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amt(logic [5:0] j);
      logic [4:0] s;
      case ({j[5:4], j[1:0]})
         4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
      endcase
      return s;
   endfunction

   function automatic logic [3:0] msg_index(logic [5:0] j);
      logic [3:0] jl;
      logic [3:0] g;
      jl = j[3:0];
      case (j[5:4])
         2'd0:    g = jl;
         2'd1:    g = jl * 4'd5 + 4'd1;
         2'd2:    g = jl * 4'd3 + 4'd5;
         default: g = jl * 4'd7;
      endcase
      return g;
   endfunction

   function automatic logic [31:0] round_f(logic [1:0] q, logic [31:0] b,
                                           logic [31:0] c, logic [31:0] d);
      logic [31:0] f;
      case (q)
         2'd0:    f = (b & c) | (~b & d);
         2'd1:    f = (d & b) | (~d & c);
         2'd2:    f = b ^ c ^ d;
         default: f = c ^ (b | ~d);
      endcase
      return f;
   endfunction

endpackage

// ----- rtl/md5_hash_engine.sv -----
// MD5 engine top level: microcoded sequencer, block buffer, round datapath and digest output.
//
// req channel: one beat per 32-bit message word, first byte in bits 7:0. tlast marks
// the final word of a message and tuser then gives its valid byte count (0..4, 5..7
// taken as 4). rsp channel: four beats per message, chaining words A..D in order,
// tuser the word index, tlast on D.
// Words are taken one per cycle while the 16-word buffer fills. A full buffer is
// compressed by a load, 64 rounds at one round per cycle and a chain add, during
// which req_tready is low. After the last word the sequencer writes the padding and
// length words itself, one a cycle with one spare step before the length, compressing
// once or twice more; it then moves from the final chain add to its emit step, which
// loads the digest beats into the output register one per cycle unless rsp stalls.
// A stalled rsp holds its beat in the output register; the sequencer waits in its emit
// step, and once the D beat is loaded the next message may start while it waits.
// Reset is synchronous: it restores the initial chaining value and clears length,
// position, padding state and the output valid flag. The buffer itself is not cleared.
module md5_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // data_word[31:0]
   input  logic        req_tlast,   // last_word
   input  logic [2:0]  req_tuser,   // last_bytes[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word[31:0]
   output logic [1:0]  rsp_tuser,   // word_index[1:0]
   output logic        rsp_tlast    // digest_done
);

   md5he_pkg::step_type  step_ff, step_in;
   md5he_pkg::phase_type phase_ff, phase_in;
   md5he_pkg::ctl_type   ctl;

   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] work_ff  [4];
   logic [31:0] work_in  [4];
   logic [3:0]  pos_ff, pos_in;
   logic [63:0] len_ff, len_in;
   logic [5:0]  round_ff, round_in;
   logic [1:0]  emit_idx_ff, emit_idx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_index_ff, rsp_index_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [31:0] buf_mem [16];
   logic [31:0] mem_q_ff;
   logic [3:0]  rd_addr;

   logic        in_acc;
   logic [2:0]  nbytes;
   logic [31:0] in_word;
   logic        push_en;
   logic [31:0] push_word;
   logic        wrap;
   logic        emit_load;
   logic        emit_last;

   logic [31:0] f_val;
   logic [31:0] sum;
   logic [63:0] rot_wide;
   logic [31:0] new_b;

   assign ctl        = md5he_pkg::ucode(step_ff);
   assign req_tready = ctl.in_ready;
   assign in_acc     = req_tvalid && ctl.in_ready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_index_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      if (!req_tlast || req_tuser > 3'd4) begin
         nbytes = 3'd4;
      end else begin
         nbytes = req_tuser;
      end
   end

   // bytes below the count pass, the pad marker follows, zeros above
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < nbytes) begin
            in_word[8*k +: 8] = req_tdata[8*k +: 8];
         end else if (3'(k) == nbytes) begin
            in_word[8*k +: 8] = md5he_pkg::PAD_BYTE;
         end else begin
            in_word[8*k +: 8] = 8'h00;
         end
      end
   end

   // round datapath
   always_comb begin
      f_val    = md5he_pkg::round_f(round_ff[5:4], work_ff[1], work_ff[2], work_ff[3]);
      sum      = work_ff[0] + f_val + md5he_pkg::sine_k(round_ff) + mem_q_ff;
      rot_wide = {sum, sum} << md5he_pkg::rot_amt(round_ff);
      new_b    = work_ff[1] + rot_wide[63:32];
   end

   assign emit_load = ctl.emit && (!rsp_valid_ff || rsp_tready);
   assign emit_last = (emit_idx_ff == 2'd3);

   always_comb begin
      push_en      = 1'b0;
      push_word    = '0;
      phase_in     = phase_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      round_in     = round_ff;
      emit_idx_in  = emit_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;

      if (in_acc) begin
         push_en   = 1'b1;
         push_word = in_word;
         len_in    = len_ff + 64'({nbytes, 3'b000});
         if (req_tlast) begin
            phase_in = (nbytes == 3'd4) ? md5he_pkg::PH_MARK : md5he_pkg::PH_ZERO;
         end
      end

      if (ctl.pad_push) begin
         case (phase_ff)
            md5he_pkg::PH_MARK: begin
               push_en   = 1'b1;
               push_word = 32'(md5he_pkg::PAD_BYTE);
               phase_in  = md5he_pkg::PH_ZERO;
            end
            md5he_pkg::PH_ZERO: begin
               if (pos_ff == 4'd14) begin
                  phase_in = md5he_pkg::PH_LEN;
               end else begin
                  push_en = 1'b1;
               end
            end
            md5he_pkg::PH_LEN: begin
               push_en   = 1'b1;
               push_word = pos_ff[0] ? len_ff[63:32] : len_ff[31:0];
            end
            default: begin
               push_en = 1'b0;
            end
         endcase
      end

      if (push_en) begin
         pos_in = pos_ff + 4'd1;
      end

      if (ctl.work_load) begin
         work_in  = chain_ff;
         round_in = '0;
      end

      if (ctl.round_en) begin
         work_in[0] = work_ff[3];
         work_in[1] = new_b;
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
         round_in   = round_ff + 6'd1;
      end

      if (ctl.chain_add) begin
         for (int i = 0; i < 4; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = chain_ff[emit_idx_ff];
         rsp_index_in = emit_idx_ff;
         rsp_last_in  = emit_last;
         emit_idx_in  = emit_idx_ff + 2'd1;
         if (emit_last) begin
            chain_in[0] = md5he_pkg::INIT_A;
            chain_in[1] = md5he_pkg::INIT_B;
            chain_in[2] = md5he_pkg::INIT_C;
            chain_in[3] = md5he_pkg::INIT_D;
            len_in      = '0;
            pos_in      = '0;
            phase_in    = md5he_pkg::PH_NONE;
         end
      end
   end

   assign wrap    = push_en && (pos_ff == 4'd15);
   assign rd_addr = md5he_pkg::msg_index(round_in);

   // sequencer jumps
   always_comb begin
      step_in = step_ff;
      case (ctl.jmp)
         md5he_pkg::J_INPUT: begin
            if (in_acc) begin
               if (wrap) begin
                  step_in = md5he_pkg::S_CLOAD;
               end else if (req_tlast) begin
                  step_in = md5he_pkg::S_PAD;
               end
            end
         end
         md5he_pkg::J_WRAP: begin
            if (wrap) begin
               step_in = md5he_pkg::S_CLOAD;
            end
         end
         md5he_pkg::J_NEXT: begin
            step_in = step_ff + md5he_pkg::step_type'(1);
         end
         md5he_pkg::J_LOOP: begin
            if (round_ff == md5he_pkg::LAST_ROUND) begin
               step_in = step_ff + md5he_pkg::step_type'(1);
            end
         end
         md5he_pkg::J_RET: begin
            if (phase_ff == md5he_pkg::PH_NONE) begin
               step_in = md5he_pkg::S_IDLE;
            end else if (phase_ff == md5he_pkg::PH_LEN && pos_ff == 4'd0) begin
               step_in = md5he_pkg::S_EMIT;
            end else begin
               step_in = md5he_pkg::S_PAD;
            end
         end
         md5he_pkg::J_EMIT: begin
            if (emit_load && emit_last) begin
               step_in = md5he_pkg::S_IDLE;
            end
         end
         default: begin
            step_in = md5he_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         buf_mem[pos_ff] <= push_word;
      end
      mem_q_ff <= buf_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         step_ff      <= md5he_pkg::S_IDLE;
         phase_ff     <= md5he_pkg::PH_NONE;
         chain_ff[0]  <= md5he_pkg::INIT_A;
         chain_ff[1]  <= md5he_pkg::INIT_B;
         chain_ff[2]  <= md5he_pkg::INIT_C;
         chain_ff[3]  <= md5he_pkg::INIT_D;
         work_ff      <= '{default: '0};
         pos_ff       <= '0;
         len_ff       <= '0;
         round_ff     <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         chain_ff     <= chain_in;
         work_ff      <= work_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         round_ff     <= round_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_round_only_in_loop: assert property (@(posedge clock) disable iff (reset)
      (round_ff != 6'd0) |-> (step_ff == md5he_pkg::S_ROUND))
      else $error("round counter running outside the round step");

   a_emit_after_length: assert property (@(posedge clock) disable iff (reset)
      (step_ff == md5he_pkg::S_EMIT) |-> (phase_ff == md5he_pkg::PH_LEN && pos_ff == 4'd0))
      else $error("digest emitted before the length block");

   a_plain_block_returns: assert property (@(posedge clock) disable iff (reset)
      (step_ff == md5he_pkg::S_CADD && phase_ff == md5he_pkg::PH_NONE)
      |=> (step_ff == md5he_pkg::S_IDLE))
      else $error("sequencer did not return to idle after a message block");

   a_done_on_d: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == 2'd3))
      else $error("digest done flagged on a word other than D");

endmodule
